/* rtl/rleicon_pkg.sv */
package rleicon_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_FULL_W = 18;
  localparam int unsigned STRIDE_W    = 9;
  localparam int unsigned RUN_LEN_W   = 6;
  localparam int unsigned LIT_BITS    = 7;

  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_DRAW_COLOR = 2'd2;

  localparam logic [7:0] DRAW_COLOR_RESET = 8'h01;

  typedef enum logic [1:0] {
    OP_START,
    OP_RUN,
    OP_LIT,
    OP_ERR
  } cmd_op_e;

  typedef enum logic [1:0] {
    PH_WIDTH,
    PH_HEIGHT,
    PH_COUNT,
    PH_PAYLOAD
  } phase_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] code;
    logic [7:0] height;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage

/* rtl/rleicon_front.sv */
module rleicon_front
  import rleicon_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] code_byte_i,
  input  logic       first_byte_i,
  input  logic       q_full_i,
  output push_t      push_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] width_q, width_d;
  logic [7:0] height_q, height_d;
  logic [7:0] left_q, left_d;
  logic       dead_q, dead_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // header and payload classification
  always_comb begin
    phase_d  = phase_q;
    width_d  = width_q;
    height_d = height_q;
    left_d   = left_q;
    dead_d   = dead_q;
    if (accept) begin
      if (first_byte_i) begin
        width_d = code_byte_i;
        phase_d = PH_HEIGHT;
        dead_d  = 1'b0;
      end else if (!dead_q) begin
        case (phase_q)
          PH_HEIGHT: begin
            height_d = code_byte_i;
            phase_d  = PH_COUNT;
          end
          PH_COUNT: begin
            left_d  = code_byte_i;
            phase_d = PH_PAYLOAD;
            if (width_q == 8'd0 || height_q == 8'd0) begin
              dead_d = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            if (left_q == 8'd0) begin
              dead_d = 1'b1;
            end else begin
              left_d = left_q - 8'd1;
            end
          end
          default: begin
            dead_d = 1'b1;
          end
        endcase
      end
    end
  end

  // request to the back end
  always_comb begin
    push_o.valid      = 1'b0;
    push_o.cmd.op     = OP_START;
    push_o.cmd.code   = code_byte_i;
    push_o.cmd.height = height_q;
    if (accept && !first_byte_i && !dead_q) begin
      case (phase_q)
        PH_COUNT: begin
          push_o.valid    = 1'b1;
          push_o.cmd.op   = OP_START;
          push_o.cmd.code = width_q;
        end
        PH_PAYLOAD: begin
          push_o.valid = 1'b1;
          if (left_q == 8'd0) begin
            push_o.cmd.op = OP_ERR;
          end else if (code_byte_i[7]) begin
            push_o.cmd.op = OP_RUN;
          end else begin
            push_o.cmd.op = OP_LIT;
          end
        end
        default: begin
          push_o.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WIDTH;
      width_q  <= 8'd0;
      height_q <= 8'd0;
      left_q   <= 8'd0;
      dead_q   <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      width_q  <= width_d;
      height_q <= height_d;
      left_q   <= left_d;
      dead_q   <= dead_d;
    end
  end

endmodule

/* rtl/rleicon_queue.sv */
module rleicon_queue
  import rleicon_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output logic  valid_o,
  output cmd_t  cmd_o,
  input  logic  pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

/* rtl/rleicon_back.sv */
module rleicon_back
  import rleicon_pkg::*;
#(
  parameter int unsigned LINE_STRIDE = 128,
  parameter int unsigned FB_COLUMNS  = 168
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  origin_x_i,
  input  logic [7:0]  origin_y_i,
  input  logic [7:0]  draw_color_i,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_address_o,
  output logic        pixel_on_o,
  output logic [7:0]  pixel_color_o,
  output logic        last_o,
  output logic        icon_done_o,
  output logic        encoding_error_o,
  output logic        outside_buffer_o
);

  localparam logic [ADDR_FULL_W-1:0] FB_LIMIT  = ADDR_FULL_W'(FB_COLUMNS * LINE_STRIDE);
  localparam logic [STRIDE_W-1:0]    STRIDE_V  = STRIDE_W'(LINE_STRIDE);

  logic                 active_q, active_d;
  logic [7:0]           width_q, width_d;
  logic [7:0]           height_q, height_d;
  logic [7:0]           col_q, col_d;
  logic [7:0]           row_q, row_d;
  logic                 busy_q, busy_d;
  logic                 is_run_q, is_run_d;
  logic                 run_bit_q, run_bit_d;
  logic [LIT_BITS-1:0]  bits_q, bits_d;
  logic [RUN_LEN_W-1:0] left_q, left_d;

  logic                 out_free;
  logic                 emit_pix, emit_err;
  logic                 pix_val, pix_last, pix_done;
  logic [7:0]           row_inc, col_inc;
  logic [8:0]           col_sum, row_sum;
  logic [ADDR_FULL_W-1:0] prod, addr_full;

  assign out_free = !out_valid_o || !out_stall_i;
  assign pix_val  = is_run_q ? run_bit_q : bits_q[0];
  assign row_inc  = row_q + 8'd1;
  assign col_inc  = col_q + 8'd1;
  assign pix_done = (row_inc >= height_q) && (col_inc >= width_q);
  assign pix_last = (left_q == RUN_LEN_W'(1)) || pix_done;

  assign col_sum   = {1'b0, origin_x_i} + {1'b0, col_q};
  assign row_sum   = {1'b0, origin_y_i} + {1'b0, row_q};
  assign prod      = ADDR_FULL_W'(col_sum) * ADDR_FULL_W'(STRIDE_V);
  assign addr_full = prod + ADDR_FULL_W'(row_sum);

  assign emit_pix = busy_q && out_free;
  assign q_pop_o  = !busy_q && q_valid_i && out_free;
  assign emit_err = q_pop_o && (q_cmd_i.op == OP_ERR) && active_q;

  always_comb begin
    active_d  = active_q;
    width_d   = width_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    busy_d    = busy_q;
    is_run_d  = is_run_q;
    run_bit_d = run_bit_q;
    bits_d    = bits_q;
    left_d    = left_q;
    if (emit_pix) begin
      left_d = left_q - RUN_LEN_W'(1);
      bits_d = bits_q >> 1;
      busy_d = !pix_last;
      if (row_inc >= height_q) begin
        row_d = 8'd0;
        col_d = col_inc;
      end else begin
        row_d = row_inc;
      end
      if (pix_done) begin
        active_d = 1'b0;
      end
    end else if (q_pop_o) begin
      case (q_cmd_i.op)
        OP_START: begin
          width_d  = q_cmd_i.code;
          height_d = q_cmd_i.height;
          col_d    = 8'd0;
          row_d    = 8'd0;
          active_d = (q_cmd_i.code != 8'd0) && (q_cmd_i.height != 8'd0);
        end
        OP_RUN: begin
          is_run_d  = 1'b1;
          run_bit_d = q_cmd_i.code[6];
          left_d    = q_cmd_i.code[RUN_LEN_W-1:0];
          busy_d    = active_q && (q_cmd_i.code[RUN_LEN_W-1:0] != '0);
        end
        OP_LIT: begin
          is_run_d = 1'b0;
          bits_d   = q_cmd_i.code[LIT_BITS-1:0];
          left_d   = RUN_LEN_W'(LIT_BITS);
          busy_d   = active_q;
        end
        OP_ERR: begin
          active_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      active_q <= active_d;
      busy_q   <= busy_d;
      if (out_free) begin
        out_valid_o <= emit_pix || emit_err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    width_q   <= width_d;
    height_q  <= height_d;
    col_q     <= col_d;
    row_q     <= row_d;
    is_run_q  <= is_run_d;
    run_bit_q <= run_bit_d;
    bits_q    <= bits_d;
    left_q    <= left_d;
    if (emit_pix) begin
      pixel_address_o  <= addr_full[15:0];
      pixel_on_o       <= pix_val;
      pixel_color_o    <= pix_val ? draw_color_i : 8'd0;
      last_o           <= pix_last;
      icon_done_o      <= pix_done;
      encoding_error_o <= 1'b0;
      outside_buffer_o <= (addr_full >= FB_LIMIT);
    end else if (emit_err) begin
      pixel_address_o  <= 16'd0;
      pixel_on_o       <= 1'b0;
      pixel_color_o    <= 8'd0;
      last_o           <= 1'b1;
      icon_done_o      <= 1'b0;
      encoding_error_o <= 1'b1;
      outside_buffer_o <= 1'b0;
    end
  end

endmodule

/* rtl/rle_icon_pixel_decoder.sv */
// channel  | valid       | flow control | payload
// input    | in_valid_i  | in_stall_o   | code_byte_i, first_byte_i
// output   | out_valid_o | out_stall_i  | pixel_address_o .. outside_buffer_o
// config   | cfg_valid_i | cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one pixel per cycle from the back end's single address unit while out_stall_i is low; it
// pops a request only when idle, so no new byte's pixels start before the last byte's end.
// a literal byte gives at most 7 pixels, a run byte at most its length, header bytes none.
// the front end takes a byte per cycle while the two-entry queue has room.
// reset is asynchronous: queue empty, decoder idle until a first byte, color 1.
// out_stall_i holds the output register; the back end then waits on its pixel.
module rle_icon_pixel_decoder
  import rleicon_pkg::*;
#(
  parameter int unsigned LINE_STRIDE = 128,
  parameter int unsigned FB_COLUMNS  = 168
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_address_o,
  output logic        pixel_on_o,
  output logic [7:0]  pixel_color_o,
  output logic        last_o,
  output logic        icon_done_o,
  output logic        encoding_error_o,
  output logic        outside_buffer_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] origin_x_q, origin_y_q, draw_color_q;
  push_t      push;
  logic       q_full, q_valid, q_pop;
  cmd_t       q_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= 8'd0;
      origin_y_q   <= 8'd0;
      draw_color_q <= DRAW_COLOR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        REG_DRAW_COLOR: draw_color_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rleicon_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_byte_i  (code_byte_i),
    .first_byte_i (first_byte_i),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  rleicon_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  rleicon_back #(
    .LINE_STRIDE (LINE_STRIDE),
    .FB_COLUMNS  (FB_COLUMNS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .origin_x_i       (origin_x_q),
    .origin_y_i       (origin_y_q),
    .draw_color_i     (draw_color_q),
    .q_valid_i        (q_valid),
    .q_cmd_i          (q_cmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_address_o  (pixel_address_o),
    .pixel_on_o       (pixel_on_o),
    .pixel_color_o    (pixel_color_o),
    .last_o           (last_o),
    .icon_done_o      (icon_done_o),
    .encoding_error_o (encoding_error_o),
    .outside_buffer_o (outside_buffer_o)
  );

endmodule
